// ===== sv/alpha_weighted_mip_downsample_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the alpha-weighted mip downsample unit
// Used by the port checker; clk and arst_n must be visible at the use site.
// ----------------------------------------------------------------------------
`ifndef ALPHA_WEIGHTED_MIP_DOWNSAMPLE_UNIT_DEFINES_SVH
`define ALPHA_WEIGHTED_MIP_DOWNSAMPLE_UNIT_DEFINES_SVH

// same-cycle implication
`define AWMD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define AWMD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/awmd_pkg.sv =====
// ----------------------------------------------------------------------------
// awmd_pkg
// Types and constants for the alpha-weighted 2x2 mip downsample unit.
// ----------------------------------------------------------------------------
`default_nettype none

package awmd_pkg;

	localparam int AWMD_MAX_WIDTH = 4096;

	localparam int CH_W    = 8;
	localparam int PSUM_W  = 9;   // pair alpha sum (or mono red sum)
	localparam int PC_W    = 17;  // pair sum of colour * alpha
	localparam int ASUM_W  = 10;  // box alpha sum
	localparam int DVD_W   = 18;  // dividend: box c*a sum plus half alpha sum
	localparam int SRCW_W  = 13;
	localparam int SRCH_W  = 16;
	localparam int CNT_W   = 16;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	typedef logic [PC_W-1:0]  pc_t;
	typedef logic [DVD_W-1:0] dvd_t;

	typedef struct packed {
		logic [PSUM_W-1:0] alpha_sum;
		pc_t [2:0]         weighted;
		logic [23:0]       corner;
	} line_entry_t;

	localparam int LINE_W = $bits(line_entry_t);

	typedef enum logic [1:0] {
		REG_SRC_WIDTH  = 2'd0,
		REG_SRC_HEIGHT = 2'd1,
		REG_MONO_MODE  = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

// ===== sv/awmd_line_ram.sv =====
// ----------------------------------------------------------------------------
// awmd_line_ram
// One-row line buffer of partial box sums; one write, one registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module awmd_line_ram #(
	parameter int DEPTH = awmd_pkg::AWMD_MAX_WIDTH / 2,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire                        clk,
	input  wire                        we,
	input  wire [AW-1:0]               waddr,
	input  wire awmd_pkg::line_entry_t wdata,
	input  wire                        re,
	input  wire [AW-1:0]               raddr,
	output awmd_pkg::line_entry_t      rdata
);
	import awmd_pkg::*;

	line_entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== sv/awmd_div.sv =====
// ----------------------------------------------------------------------------
// awmd_div
// Three-lane restoring divider, one quotient bit per cycle, shared divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module awmd_div (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	input  wire awmd_pkg::dvd_t [2:0]    dividend,
	input  wire [awmd_pkg::ASUM_W-1:0]   divisor,
	output logic                         done,
	output awmd_pkg::dvd_t [2:0]         quot
);
	import awmd_pkg::*;

	localparam int CW = $clog2(DVD_W + 1);

	logic [CW-1:0]         cnt_q;
	logic                  busy_q;
	logic [ASUM_W-1:0]     rem_q  [3];
	logic [ASUM_W-1:0]     rem_nx [3];
	logic [2:0]            qbit;
	logic [ASUM_W:0]       trial  [3];
	logic [ASUM_W:0]       diff   [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			trial[k]  = {rem_q[k], quot[k][DVD_W-1]};
			diff[k]   = trial[k] - {1'b0, divisor};
			qbit[k]   = (trial[k] >= {1'b0, divisor});
			rem_nx[k] = qbit[k] ? diff[k][ASUM_W-1:0] : trial[k][ASUM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			if (start) begin
				quot[k]  <= dividend[k];
				rem_q[k] <= '0;
			end else if (busy_q) begin
				quot[k]  <= {quot[k][DVD_W-2:0], qbit[k]};
				rem_q[k] <= rem_nx[k];
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/alpha_weighted_mip_downsample_unit.sv =====
// ----------------------------------------------------------------------------
// alpha_weighted_mip_downsample_unit
// Source texels in raster order in, one mip level of half size out.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (in_red..in_alpha) arrive on in_valid/in_ready in raster order.
//   Output words (out_*, end_of_row, last_texel) leave on out_valid/out_ready,
//   one per 2x2 box; end_of_row and last_texel flag row and level ends.
//   Registers: 0x0 src_width, 0x4 src_height, 0x8 mono_mode. Any write,
//   also to an unused address, restarts the level at row 0, column 0.
//   Write configuration only while the unit is idle.
//   A word that only updates the line buffer or the left-texel hold is taken
//   while the unit stays idle. A word that completes a box passes through the
//   line buffer read, the sum, an 18-bit serial divide and the output load;
//   the unit takes no new word until that box is done. The divider dominates.
//   The output register holds a finished word while the receiver stalls;
//   the unit keeps taking words until the next box needs that register.
//   Reset: registers go to width 1, height 1, RGBA; position to 0; the line
//   buffer needs no clearing since every level starts on an even row.
// ----------------------------------------------------------------------------
`default_nettype none

module alpha_weighted_mip_downsample_unit #(
	parameter int MAX_WIDTH = awmd_pkg::AWMD_MAX_WIDTH
) (
	input  wire                               clk,
	input  wire                               arst_n,
	// configuration
	input  wire                               psel,
	input  wire                               penable,
	input  wire                               pwrite,
	input  wire [awmd_pkg::PADDR_W-1:0]       paddr,
	input  wire [awmd_pkg::PDATA_W-1:0]       pwdata,
	output logic [awmd_pkg::PDATA_W-1:0]      prdata,
	output logic                              pready,
	// input texels
	input  wire                               in_valid,
	output logic                              in_ready,
	input  wire [awmd_pkg::CH_W-1:0]          in_red,
	input  wire [awmd_pkg::CH_W-1:0]          in_green,
	input  wire [awmd_pkg::CH_W-1:0]          in_blue,
	input  wire [awmd_pkg::CH_W-1:0]          in_alpha,
	// output texels
	output logic                              out_valid,
	input  wire                               out_ready,
	output logic [awmd_pkg::CH_W-1:0]         out_red,
	output logic [awmd_pkg::CH_W-1:0]         out_green,
	output logic [awmd_pkg::CH_W-1:0]         out_blue,
	output logic [awmd_pkg::CH_W-1:0]         out_alpha,
	output logic                              end_of_row,
	output logic                              last_texel
);
	import awmd_pkg::*;

	localparam int LINE_DEPTH = MAX_WIDTH / 2;
	localparam int AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
	localparam int WEW        = $clog2(MAX_WIDTH + 1);

	// registers
	logic [SRCW_W-1:0] src_width_q;
	logic [SRCH_W-1:0] src_height_q;
	logic              mono_mode_q;

	logic [CNT_W-1:0]  col_q, row_q;
	logic [31:0]       hold_q;
	state_t            state_q, state_nx;

	// pair stage
	logic [PSUM_W-1:0] pa_q;
	pc_t [2:0]         pc_q;
	logic [23:0]       corner_q;
	logic              eor_q, last_q, h1_q;
	// box stage
	logic [ASUM_W-1:0] asum_q;
	logic [23:0]       tcorner_q;

	logic              cfg_wr;
	logic              acc;

	// ---------------- configuration ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= SRCW_W'(1);
			src_height_q <= SRCH_W'(1);
			mono_mode_q  <= 1'b0;
		end else if (cfg_wr) begin
			unique case (reg_idx_t'(paddr[3:2]))
				REG_SRC_WIDTH:  src_width_q  <= pwdata[SRCW_W-1:0];
				REG_SRC_HEIGHT: src_height_q <= pwdata[SRCH_W-1:0];
				REG_MONO_MODE:  mono_mode_q  <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[3:2]))
			REG_SRC_WIDTH:  prdata = PDATA_W'(src_width_q);
			REG_SRC_HEIGHT: prdata = PDATA_W'(src_height_q);
			REG_MONO_MODE:  prdata = PDATA_W'(mono_mode_q);
			default:        prdata = '0;
		endcase
	end

	// ---------------- geometry ----------------
	logic [WEW-1:0]    w_eff;
	logic [SRCH_W-1:0] h_eff;
	logic              w1, h1;
	logic [WEW-1:0]    dw;
	logic [SRCH_W-1:0] dh;
	logic              have_pair, row_in, row_odd, col_even;
	logic [AW-1:0]     px;
	logic              eor, lastt;

	always_comb begin
		if (src_width_q == '0) begin
			w_eff = WEW'(1);
		end else if (32'(src_width_q) > MAX_WIDTH) begin
			w_eff = WEW'(MAX_WIDTH);
		end else begin
			w_eff = WEW'(src_width_q);
		end
		h_eff = (src_height_q == '0) ? SRCH_W'(1) : src_height_q;
		w1    = (w_eff == WEW'(1));
		h1    = (h_eff == SRCH_W'(1));
		dw    = w1 ? WEW'(1) : (w_eff >> 1);
		dh    = h1 ? SRCH_W'(1) : (h_eff >> 1);
		col_even  = ~col_q[0];
		have_pair = w1 || ((32'(col_q) < (32'(w_eff) & ~32'd1)) && !col_even);
		px        = w1 ? '0 : AW'(col_q >> 1);
		row_in    = 32'(row_q) < (32'(h_eff) & ~32'd1);
		row_odd   = row_q[0];
		eor       = (32'(px) == 32'(dw) - 32'd1);
		lastt     = eor && (h1 || (32'(row_q >> 1) == 32'(dh) - 32'd1));
	end

	// ---------------- pair sums ----------------
	logic [31:0]       cur, left;
	logic [PSUM_W-1:0] pa;
	pc_t [2:0]         pc;

	always_comb begin
		cur  = {in_alpha, in_blue, in_green, in_red};
		left = w1 ? cur : hold_q;
		if (mono_mode_q) begin
			pa = PSUM_W'(left[7:0]) + PSUM_W'(cur[7:0]);
		end else begin
			pa = PSUM_W'(left[31:24]) + PSUM_W'(cur[31:24]);
		end
		for (int k = 0; k < 3; k++) begin
			pc[k] = PC_W'(left[8*k +: 8] * left[31:24]) + PC_W'(cur[8*k +: 8] * cur[31:24]);
		end
	end

	// ---------------- line buffer ----------------
	line_entry_t ram_wdata, ram_rdata;
	logic        ram_we, ram_re;

	assign ram_wdata.alpha_sum = pa;
	assign ram_wdata.weighted  = pc;
	assign ram_wdata.corner    = left[23:0];

	awmd_line_ram #(
		.DEPTH (LINE_DEPTH),
		.AW    (AW)
	) u_line_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (px),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (px),
		.rdata (ram_rdata)
	);

	// ---------------- divider ----------------
	logic              div_start, div_done;
	dvd_t [2:0]        div_dvd, div_q;
	line_entry_t       top;
	logic [ASUM_W-1:0] asum;

	always_comb begin
		if (h1_q) begin
			top.alpha_sum = pa_q;
			top.weighted  = pc_q;
			top.corner    = corner_q;
		end else begin
			top = ram_rdata;
		end
		asum = ASUM_W'(top.alpha_sum) + ASUM_W'(pa_q);
		for (int k = 0; k < 3; k++) begin
			div_dvd[k] = DVD_W'(top.weighted[k]) + DVD_W'(pc_q[k]) + DVD_W'(asum >> 1);
		end
	end

	awmd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (asum_q),
		.done     (div_done),
		.quot     (div_q)
	);

	// ---------------- control ----------------
	logic out_load;

	always_comb begin
		state_nx  = state_q;
		in_ready  = 1'b0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		acc       = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				acc      = in_valid;
				if (in_valid && have_pair) begin
					if (h1) begin
						state_nx = ST_LOAD;
					end else if (row_in && !row_odd) begin
						ram_we = 1'b1;
					end else if (row_in) begin
						ram_re   = 1'b1;
						state_nx = ST_LOAD;
					end
				end
			end
			ST_LOAD: begin
				div_start = 1'b1;
				state_nx  = ST_DIV;
			end
			ST_DIV: begin
				if (div_done) begin
					state_nx = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid || out_ready) begin
					out_load = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	logic [CNT_W:0] col_inc, row_inc;

	assign col_inc = {1'b0, col_q} + 1'b1;
	assign row_inc = {1'b0, row_q} + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			col_q   <= '0;
			row_q   <= '0;
			hold_q  <= '0;
		end else begin
			state_q <= state_nx;
			if (cfg_wr) begin
				col_q <= '0;
				row_q <= '0;
			end else if (acc) begin
				if (!w1 && col_even && (32'(col_q) < (32'(w_eff) & ~32'd1))) begin
					hold_q <= cur;
				end
				if (32'(col_inc) >= 32'(w_eff)) begin
					col_q <= '0;
					row_q <= (32'(row_inc) >= 32'(h_eff)) ? '0 : row_inc[CNT_W-1:0];
				end else begin
					col_q <= col_inc[CNT_W-1:0];
				end
			end
		end
	end

	// item payload registers
	always_ff @(posedge clk) begin
		if (acc) begin
			pa_q     <= pa;
			pc_q     <= pc;
			corner_q <= left[23:0];
			eor_q    <= eor;
			last_q   <= lastt;
			h1_q     <= h1;
		end
		if (div_start) begin
			asum_q    <= asum;
			tcorner_q <= top.corner;
		end
	end

	// ---------------- output register ----------------
	logic [CH_W-1:0] mean;

	assign mean = CH_W'((asum_q + ASUM_W'(2)) >> 2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			end_of_row <= eor_q;
			last_texel <= last_q;
			if (mono_mode_q) begin
				out_red   <= mean;
				out_green <= '0;
				out_blue  <= '0;
				out_alpha <= '0;
			end else begin
				// all four alphas zero: copy the top-left colour
				out_red   <= (asum_q != '0) ? div_q[0][CH_W-1:0] : tcorner_q[7:0];
				out_green <= (asum_q != '0) ? div_q[1][CH_W-1:0] : tcorner_q[15:8];
				out_blue  <= (asum_q != '0) ? div_q[2][CH_W-1:0] : tcorner_q[23:16];
				out_alpha <= mean;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/awmd_port_checker.sv =====
// ----------------------------------------------------------------------------
// awmd_port_checker
// Port-level checks for the mip downsample unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "alpha_weighted_mip_downsample_unit_defines.svh"

module awmd_port_checker (
	input wire clk,
	input wire arst_n,
	input wire in_ready,
	input wire out_valid,
	input wire out_ready,
	input wire end_of_row,
	input wire last_texel
);

	`AWMD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "output word dropped while stalled")
	`AWMD_ASSERT_NOW(a_last_eor, out_valid && last_texel, end_of_row, "last texel without end of row")
	`AWMD_ASSERT_NOW(a_load_busy, $rose(out_valid), $past(!in_ready), "output loaded while taking input")

endmodule

bind alpha_weighted_mip_downsample_unit awmd_port_checker u_awmd_port_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.end_of_row (end_of_row),
	.last_texel (last_texel)
);

`default_nettype wire
